### src/bert_pkg.sv
// Package for the button edge and auto-repeat tracker.
// Holds shared widths, register indexes and the control/status structs.
// No dependencies.
package bert_pkg;

  // Number of tracked buttons and the width of a button index.
  localparam int NUM_BUTTONS = 3;
  localparam int BTN_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  // Field widths.
  localparam int COORD_W = 16;
  localparam int POS_W   = 12;
  localparam int SIZE_W  = 13;
  localparam int CNT_W   = 16;
  localparam int MASK_W  = 3;
  localparam int CFG_D_W = 16;

  // Packed channel widths, rounded up to whole bytes.
  localparam int IN_BITS   = 5 * COORD_W + MASK_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = 2 * POS_W + 4 * MASK_W + 3 * CNT_W + 3 * COORD_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Largest screen size and the saturation point of a hold counter.
  localparam logic [SIZE_W-1:0] SCREEN_MAX = SIZE_W'(4096);
  localparam logic [CNT_W-1:0]  HOLD_MAX   = '1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_BEGIN    = 2'd2,
    CFG_INTERVAL = 2'd3
  } cfg_idx_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             accept;
    logic             mod_start;
    logic             rep_capture;
    logic             out_load;
    logic [BTN_W-1:0] btn;
  } bert_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mod_done;
    logic out_free;
  } bert_sts_t;

endpackage

### src/button_edge_repeat_tracker_top.sv
// Top level of the button edge and auto-repeat tracker.
// Depends on bert_pkg, bert_ctrl, bert_dp (and bert_mod below it).
//
//   channel  direction  handshake            payload
//   in_      input      in_tvalid/in_tready  in_tdata (88 b), in_tuser (read_ok)
//   out_     output     out_tvalid/out_tready out_tdata (136 b)
//   cfg_     input      cfg_valid/cfg_ready  cfg_index (2 b), cfg_data (16 b)
//
// Each button of an item takes a load step, the iterations of the shared
// two-bit-per-cycle remainder unit and a capture step; the result register is
// then loaded. The input is ready again in the cycle after that load, so an
// item is not taken while the last one is still being worked on. The next item
// is taken while a result still waits in that register. A result that is not
// taken stalls the next load, and with it the input. Reset is synchronous,
// active low; configuration is always ready.
module button_edge_repeat_tracker_top
  import bert_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // cursor_x, cursor_y, button_bits, delta_x, delta_y, wheel_delta, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // read_ok
  input  logic                  in_tuser,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // pos_x, pos_y, press_mask, trigger_mask, release_mask, repeat_mask,
  // hold_left, hold_right, hold_middle, move_x, move_y, wheel, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_D_W-1:0]    cfg_data
);

  bert_cmd_t cmd;
  bert_sts_t sts;

  // Configuration writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  bert_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  bert_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_fire   (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### src/bert_mod.sv
// Sequential remainder unit: 16-bit restoring division, two bits per cycle.
// Depends on bert_pkg.
module bert_mod
  import bert_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CNT_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [CNT_W-1:0] rem
);

  localparam int STEPS   = CNT_W / 2;
  localparam int STEP_W  = $clog2(STEPS);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  q_r;
  logic [CNT_W-1:0]  d_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  rem_mid;
  logic [CNT_W-1:0]  rem_nxt;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  function automatic logic [CNT_W-1:0] rem_step(input logic [CNT_W-1:0] r,
                                                input logic b,
                                                input logic [CNT_W-1:0] d);
    logic [CNT_W:0] t;
    logic [CNT_W:0] s;
    t = {r, b};
    s = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return s[CNT_W-1:0];
    end
    return t[CNT_W-1:0];
  endfunction

  // Two dependent steps per cycle.
  always_comb begin
    rem_mid = rem_step(rem_r, q_r[CNT_W-1], d_r);
    rem_nxt = rem_step(rem_mid, q_r[CNT_W-2], d_r);
  end

  // Iteration control and operand registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      d_r   <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[CNT_W-3:0], 2'b00};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

### src/bert_dp.sv
// Datapath of the tracker: configuration, button state, repeat test, result register.
// Depends on bert_pkg and bert_mod.
module bert_dp
  import bert_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  bert_cmd_t               cmd,
  output bert_sts_t               sts,
  // Configuration writes
  input  logic                    cfg_fire,
  input  logic [1:0]              cfg_index,
  input  logic [CFG_D_W-1:0]      cfg_data,
  // Input item fields
  input  logic [IN_DATA_W-1:0]    in_tdata,
  input  logic                    in_tuser,
  // Result channel
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_DATA_W-1:0]   out_tdata
);

  // Configuration registers
  logic [SIZE_W-1:0] width_r;
  logic [SIZE_W-1:0] height_r;
  logic [CNT_W-1:0]  begin_r;
  logic [CNT_W-1:0]  interval_r;

  // Button and motion state
  logic [NUM_BUTTONS-1:0] held_r;
  logic [NUM_BUTTONS-1:0] rise_r;
  logic [NUM_BUTTONS-1:0] fall_r;
  logic [CNT_W-1:0]       hold_r [NUM_BUTTONS];
  logic [CNT_W-1:0]       hold_nxt [NUM_BUTTONS];
  logic [COORD_W-1:0]     last_dx_r;
  logic [COORD_W-1:0]     last_dy_r;
  logic [COORD_W-1:0]     last_wheel_r;

  // Per-item working registers
  logic [POS_W-1:0]       pos_x_r;
  logic [POS_W-1:0]       pos_y_r;
  logic [NUM_BUTTONS-1:0] rep_r;
  logic                   eq1_r;
  logic                   ge_r;

  // Result register
  logic                   out_valid_r;
  logic [OUT_DATA_W-1:0]  out_data_r;

  // Unpacked input fields
  logic signed [COORD_W-1:0] cursor_x;
  logic signed [COORD_W-1:0] cursor_y;
  logic [MASK_W-1:0]         button_bits;
  logic [COORD_W-1:0]        delta_x;
  logic [COORD_W-1:0]        delta_y;
  logic [COORD_W-1:0]        wheel_delta;
  logic [NUM_BUTTONS+MASK_W-1:0] btn_ext;
  logic [NUM_BUTTONS-1:0]    now_bits;

  // Remainder unit connections
  logic [CNT_W-1:0] sel_cnt;
  logic [CNT_W-1:0] mod_dividend;
  logic [CNT_W-1:0] mod_divisor;
  logic             mod_done;
  logic [CNT_W-1:0] mod_rem;

  // Result assembly
  logic [NUM_BUTTONS+MASK_W-1:0] held_ext;
  logic [NUM_BUTTONS+MASK_W-1:0] rise_ext;
  logic [NUM_BUTTONS+MASK_W-1:0] fall_ext;
  logic [NUM_BUTTONS+MASK_W-1:0] rep_ext;
  logic [CNT_W-1:0]              hold_out [MASK_W];
  logic [OUT_BITS-1:0]           result;

  // Clamp a signed coordinate into 0..size-1, with size forced into 1..4096.
  function automatic logic [POS_W-1:0] clamp_axis(input logic signed [COORD_W-1:0] c,
                                                  input logic [SIZE_W-1:0] sz);
    logic [SIZE_W-1:0] s;
    logic [SIZE_W-1:0] lim;
    s = sz;
    if (s == '0) begin
      s = SIZE_W'(1);
    end
    if (s > SCREEN_MAX) begin
      s = SCREEN_MAX;
    end
    lim = s - 1'b1;
    if (c < 0) begin
      return '0;
    end
    if ($unsigned(c) >= {{(COORD_W-SIZE_W){1'b0}}, s}) begin
      return lim[POS_W-1:0];
    end
    return c[POS_W-1:0];
  endfunction

  // Field extraction, lowest field first.
  assign cursor_x    = in_tdata[15:0];
  assign cursor_y    = in_tdata[31:16];
  assign button_bits = in_tdata[34:32];
  assign delta_x     = in_tdata[50:35];
  assign delta_y     = in_tdata[66:51];
  assign wheel_delta = in_tdata[82:67];
  assign btn_ext     = (NUM_BUTTONS + MASK_W)'(button_bits);
  assign now_bits    = btn_ext[NUM_BUTTONS-1:0];

  // Configuration registers; writes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= SIZE_W'(1);
      height_r   <= SIZE_W'(1);
      begin_r    <= CNT_W'(30);
      interval_r <= CNT_W'(5);
    end else if (cfg_fire) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:    width_r    <= cfg_data[SIZE_W-1:0];
        CFG_HEIGHT:   height_r   <= cfg_data[SIZE_W-1:0];
        CFG_BEGIN:    begin_r    <= cfg_data;
        CFG_INTERVAL: interval_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next hold counts: count up to saturation while held, clear on release.
  always_comb begin
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      if (!now_bits[b]) begin
        hold_nxt[b] = '0;
      end else if (hold_r[b] != HOLD_MAX) begin
        hold_nxt[b] = hold_r[b] + 1'b1;
      end else begin
        hold_nxt[b] = hold_r[b];
      end
    end
  end

  // Button state is taken only from a valid sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= '0;
      rise_r       <= '0;
      fall_r       <= '0;
      last_dx_r    <= '0;
      last_dy_r    <= '0;
      last_wheel_r <= '0;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        hold_r[b] <= '0;
      end
    end else if (cmd.accept && in_tuser) begin
      held_r       <= now_bits;
      rise_r       <= now_bits & ~held_r;
      fall_r       <= held_r & ~now_bits;
      last_dx_r    <= delta_x;
      last_dy_r    <= delta_y;
      last_wheel_r <= wheel_delta;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        hold_r[b] <= hold_nxt[b];
      end
    end
  end

  // Operands of the repeat test for the selected button.
  always_comb begin
    sel_cnt      = hold_r[cmd.btn];
    mod_dividend = sel_cnt - begin_r;
    mod_divisor  = (interval_r == '0) ? CNT_W'(1) : interval_r;
  end

  bert_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mod_start),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Cursor clamp on transfer, then the repeat bits one button at a time.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pos_x_r <= clamp_axis(cursor_x, width_r);
      pos_y_r <= clamp_axis(cursor_y, height_r);
      rep_r   <= '0;
    end
    if (cmd.mod_start) begin
      eq1_r <= (sel_cnt == CNT_W'(1));
      ge_r  <= (sel_cnt >= begin_r);
    end
    if (cmd.rep_capture) begin
      rep_r[cmd.btn] <= eq1_r | (ge_r & (mod_rem == '0));
    end
  end

  // Output masks keep the three low bits; missing buttons read as zero.
  assign held_ext = (NUM_BUTTONS + MASK_W)'(held_r);
  assign rise_ext = (NUM_BUTTONS + MASK_W)'(rise_r);
  assign fall_ext = (NUM_BUTTONS + MASK_W)'(fall_r);
  assign rep_ext  = (NUM_BUTTONS + MASK_W)'(rep_r);

  for (genvar g = 0; g < MASK_W; g++) begin : g_hold
    if (g < NUM_BUTTONS) begin : g_on
      assign hold_out[g] = hold_r[g];
    end else begin : g_off
      assign hold_out[g] = '0;
    end
  end

  assign result = {last_wheel_r, last_dy_r, last_dx_r,
                   hold_out[2], hold_out[1], hold_out[0],
                   rep_ext[MASK_W-1:0], fall_ext[MASK_W-1:0],
                   rise_ext[MASK_W-1:0], held_ext[MASK_W-1:0],
                   pos_y_r, pos_x_r};

  // Result register, freed by an output transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= OUT_DATA_W'(result);
    end
  end

  assign sts.mod_done = mod_done;
  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;

endmodule

### src/bert_ctrl.sv
// Controller of the tracker: takes an item, steps the repeat test over the buttons.
// Depends on bert_pkg.
module bert_ctrl
  import bert_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output bert_cmd_t cmd,
  input  bert_sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_DONE
  } state_t;

  state_t           state_r;
  logic             ready_r;
  logic [BTN_W-1:0] btn_r;

  // Commands decoded from the state.
  always_comb begin
    cmd             = '0;
    cmd.btn         = btn_r;
    cmd.accept      = ready_r && in_tvalid;
    cmd.mod_start   = (state_r == S_START);
    cmd.rep_capture = (state_r == S_WAIT) && sts.mod_done;
    cmd.out_load    = (state_r == S_DONE) && sts.out_free;
  end

  // State, ready and button counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ready_r <= 1'b1;
      btn_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (ready_r && in_tvalid) begin
            ready_r <= 1'b0;
            btn_r   <= '0;
            state_r <= S_START;
          end
        end
        S_START: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (sts.mod_done) begin
            if (btn_r == BTN_W'(NUM_BUTTONS - 1)) begin
              state_r <= S_DONE;
            end else begin
              btn_r   <= btn_r + 1'b1;
              state_r <= S_START;
            end
          end
        end
        S_DONE: begin
          if (sts.out_free) begin
            ready_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: begin
          ready_r <= 1'b1;
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready = ready_r;

endmodule
